// File: hdl/s2w_pkg.sv
// Shared types, constants and the arctangent table for the scan-to-world point pipeline.
`timescale 1ns / 1ps

package s2w_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;

    // Beams at or beyond this index are outside the scan.
    localparam logic [16:0] MAX_BEAMS = 17'd4096;

    localparam int COORD_W = 48;
    localparam int MAG_W   = 46;
    localparam int ANGLE_W = 32;

    // 1/K of the CORDIC gain in Q30.
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

    localparam logic signed [25:0] S24_MAX = 26'sd8388607;
    localparam logic signed [25:0] S24_MIN = -26'sd8388608;

    // Configuration register indexes.
    localparam logic [2:0] REG_ROBOT_X    = 3'd0;
    localparam logic [2:0] REG_ROBOT_Y    = 3'd1;
    localparam logic [2:0] REG_HEADING    = 3'd2;
    localparam logic [2:0] REG_START      = 3'd3;
    localparam logic [2:0] REG_STEP       = 3'd4;
    localparam logic [2:0] REG_MIN_RANGE  = 3'd5;
    localparam logic [2:0] REG_MAX_RANGE  = 3'd6;
    localparam logic [2:0] REG_RADIUS     = 3'd7;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [23:0] robot_x;
        logic signed [23:0] robot_y;
        logic [15:0]        heading;
        logic [15:0]        start_angle;
        logic [15:0]        angle_step;
        logic [15:0]        min_range;
        logic [15:0]        max_range;
        logic [15:0]        radius;
    } t_cfg;

    // Contents of one slot of the rotation chain.
    typedef struct packed {
        logic                       occ;
        logic                       pv;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [ANGLE_W-1:0]  z;
    } t_cell_data;

    typedef struct packed {
        logic               pv;
        logic signed [23:0] world_x;
        logic signed [23:0] world_y;
        logic [15:0]        radius;
    } t_result;

endpackage

// File: hdl/s2w_in_if.sv
// Channel interfaces for range samples in and world points out.
`timescale 1ns / 1ps

interface s2w_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] range_mm;
    logic        is_finite;
    logic [11:0] beam_index;

    modport source (output valid, range_mm, is_finite, beam_index, input ready);
    modport sink   (input valid, range_mm, is_finite, beam_index, output ready);
endinterface

interface s2w_out_if;
    logic               valid;
    logic               ready;
    logic               point_valid;
    logic signed [23:0] world_x;
    logic signed [23:0] world_y;
    logic [15:0]        point_radius;

    modport source (output valid, point_valid, world_x, world_y, point_radius,
                    input ready);
    modport sink   (input valid, point_valid, world_x, world_y, point_radius,
                    output ready);
endinterface

// File: hdl/s2w_front.sv
// Front stages: range checks, beam angle, quadrant fold and CORDIC start vector.
`timescale 1ns / 1ps

module s2w_front import s2w_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [15:0] i_range_mm,
    input  logic        i_is_finite,
    input  logic [11:0] i_beam_index,
    input  t_cfg        i_cfg,
    output t_cell_data  o_data
);

    localparam logic [1:0] QUAD_EAST  = 2'd0;
    localparam logic [1:0] QUAD_NORTH = 2'd1;
    localparam logic [1:0] QUAD_WEST  = 2'd2;
    localparam logic [1:0] QUAD_SOUTH = 2'd3;

    logic             r_a_occ;
    logic             r_a_pv;
    logic [MAG_W-1:0] r_a_mag;
    logic [15:0]      r_a_prod;
    logic             n_a_pv;
    logic [27:0]      n_a_prod_full;

    t_cell_data r_b;
    t_cell_data n_b;

    logic [15:0]               w_ang;
    logic [15:0]               w_ang_bias;
    logic [1:0]                w_quad;
    logic [15:0]               w_res;
    logic signed [COORD_W-1:0] w_mag;

    always_comb begin
        n_a_pv = i_is_finite && (i_range_mm >= i_cfg.min_range)
                 && (i_range_mm <= i_cfg.max_range)
                 && ({5'b0, i_beam_index} < MAX_BEAMS);
        n_a_prod_full = 28'(i_beam_index) * 28'(i_cfg.angle_step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_occ <= 1'b0;
        end else if (i_en) begin
            r_a_occ <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_pv   <= n_a_pv;
            r_a_mag  <= MAG_W'(i_range_mm) * MAG_W'(INV_GAIN_Q30);
            r_a_prod <= n_a_prod_full[15:0];
        end
    end

    always_comb begin
        w_ang      = i_cfg.heading + i_cfg.start_angle + r_a_prod;
        w_ang_bias = w_ang + 16'd8192;
        w_quad     = w_ang_bias[15:14];
        // Residual lies in [-8192, 8191] once the nearest quarter turn is removed.
        w_res      = w_ang - {w_quad, 14'b0};
        w_mag      = $signed({2'b0, r_a_mag});

        n_b     = '0;
        n_b.occ = r_a_occ;
        n_b.pv  = r_a_pv;
        n_b.z   = $signed({w_res, 16'b0});
        case (w_quad)
            QUAD_EAST: begin
                n_b.x = w_mag;
                n_b.y = '0;
            end
            QUAD_NORTH: begin
                n_b.x = '0;
                n_b.y = w_mag;
            end
            QUAD_WEST: begin
                n_b.x = -w_mag;
                n_b.y = '0;
            end
            QUAD_SOUTH: begin
                n_b.x = '0;
                n_b.y = -w_mag;
            end
            default: begin
                n_b.x = '0;
                n_b.y = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.occ <= 1'b0;
        end else if (i_en) begin
            r_b <= n_b;
        end
    end

    assign o_data = r_b;

endmodule

// File: hdl/s2w_cell.sv
// One CORDIC rotation cell: a single micro-rotation and its register.
`timescale 1ns / 1ps

module s2w_cell import s2w_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_cell_data i_data,
    output t_cell_data o_data
);

    t_cell_data r_data;
    t_cell_data n_data;

    logic signed [COORD_W-1:0] w_dx;
    logic signed [COORD_W-1:0] w_dy;
    logic signed [ANGLE_W-1:0] w_atan;

    always_comb begin
        w_dx   = i_data.y >>> STEP;
        w_dy   = i_data.x >>> STEP;
        w_atan = $signed(ATAN_TURNS[STEP]);
        n_data = i_data;
        if (!i_data.z[ANGLE_W-1]) begin
            n_data.x = i_data.x - w_dx;
            n_data.y = i_data.y + w_dy;
            n_data.z = i_data.z - w_atan;
        end else begin
            n_data.x = i_data.x + w_dx;
            n_data.y = i_data.y - w_dy;
            n_data.z = i_data.z + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.occ <= 1'b0;
        end else if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

// File: hdl/s2w_back.sv
// Back stage: rounding to millimetres, robot offset, saturation and output register.
`timescale 1ns / 1ps

module s2w_back import s2w_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_cell_data i_data,
    input  t_cfg       i_cfg,
    output logic       o_valid,
    output t_result    o_result
);

    localparam logic signed [COORD_W-1:0] HALF_Q30 = COORD_W'(64'sd536870912);

    logic                      r_valid;
    t_result                   r_result;
    t_result                   n_result;
    logic signed [COORD_W-1:0] w_rx;
    logic signed [COORD_W-1:0] w_ry;
    logic signed [25:0]        w_sx;
    logic signed [25:0]        w_sy;

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        logic signed [23:0] res;
        if (v > S24_MAX) begin
            res = S24_MAX[23:0];
        end else if (v < S24_MIN) begin
            res = S24_MIN[23:0];
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

    always_comb begin
        w_rx = (i_data.x + HALF_Q30) >>> 30;
        w_ry = (i_data.y + HALF_Q30) >>> 30;
        // The rounded offsets stay within 18 bits, so 26 bits hold the sums.
        w_sx = 26'(i_cfg.robot_x) + w_rx[25:0];
        w_sy = 26'(i_cfg.robot_y) + w_ry[25:0];
        n_result = '0;
        if (i_data.pv) begin
            n_result.pv      = 1'b1;
            n_result.world_x = sat24(w_sx);
            n_result.world_y = sat24(w_sy);
            n_result.radius  = i_cfg.radius;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_data.occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: hdl/scan_to_world_points.sv
// Top level: lidar range samples to saturated world-frame obstacle points.
//
//   Channel  Direction  Payload
//   i_in     in         range_mm, is_finite, beam_index
//   o_out    out        point_valid, world_x, world_y, point_radius
//   i_cfg_*  in         register writes: index, data (no read-back)
//
// One sample is taken every cycle while the output is not stalled; each gives exactly one point
// after passing two front stages, one cell per rotation and one output stage.
// The whole chain of cells moves together; it holds while a point waits untaken in the output
// register, and bubbles travel through it like items.
// Reset is synchronous; it clears the occupancy bits and loads the configuration registers with their defaults.
`timescale 1ns / 1ps

module scan_to_world_points import s2w_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    s2w_in_if.sink      i_in,
    s2w_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);

    localparam int NCELLS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    t_cfg       r_cfg;
    logic       w_en;
    logic       w_out_valid;
    t_result    w_result;
    t_cell_data w_chain [NCELLS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.robot_x     <= '0;
            r_cfg.robot_y     <= '0;
            r_cfg.heading     <= '0;
            r_cfg.start_angle <= '0;
            r_cfg.angle_step  <= 16'd182;
            r_cfg.min_range   <= '0;
            r_cfg.max_range   <= 16'd65535;
            r_cfg.radius      <= 16'd150;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROBOT_X:   r_cfg.robot_x     <= i_cfg_data;
                REG_ROBOT_Y:   r_cfg.robot_y     <= i_cfg_data;
                REG_HEADING:   r_cfg.heading     <= i_cfg_data[15:0];
                REG_START:     r_cfg.start_angle <= i_cfg_data[15:0];
                REG_STEP:      r_cfg.angle_step  <= i_cfg_data[15:0];
                REG_MIN_RANGE: r_cfg.min_range   <= i_cfg_data[15:0];
                REG_MAX_RANGE: r_cfg.max_range   <= i_cfg_data[15:0];
                REG_RADIUS:    r_cfg.radius      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // The pipeline advances whenever the output register is empty or being read.
    assign w_en       = o_out.ready || !w_out_valid;
    assign i_in.ready = w_en;

    s2w_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (i_in.valid),
        .i_range_mm   (i_in.range_mm),
        .i_is_finite  (i_in.is_finite),
        .i_beam_index (i_in.beam_index),
        .i_cfg        (r_cfg),
        .o_data       (w_chain[0])
    );

    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        s2w_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_data  (w_chain[g]),
            .o_data  (w_chain[g+1])
        );
    end

    s2w_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_data   (w_chain[NCELLS]),
        .i_cfg    (r_cfg),
        .o_valid  (w_out_valid),
        .o_result (w_result)
    );

    assign o_out.valid        = w_out_valid;
    assign o_out.point_valid  = w_result.pv;
    assign o_out.world_x      = w_result.world_x;
    assign o_out.world_y      = w_result.world_y;
    assign o_out.point_radius = w_result.radius;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input transfer taken while the output is stalled");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.point_valid) |->
        (o_out.world_x == '0 && o_out.world_y == '0 && o_out.point_radius == '0))
        else $error("rejected sample carries a non-zero payload");

    a_radius_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.point_valid) |-> (o_out.point_radius == r_cfg.radius))
        else $error("point radius differs from the configured radius");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid straight after reset");

endmodule
